// File: rtl/wds_pkg.sv
// Shared types, constants and the control program for the weighted direction selector.
// Depends on nothing; the selector, the checker and the testbench import it.
package wds_pkg;

  localparam int NUM_DIRS  = 8;
  localparam int DIR_W     = 3;
  localparam int DEG_STEP  = 45;
  localparam int ANGLE_W   = 9;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SCORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND   = 2'd2;

  localparam logic [CFG_W-1:0] INITIAL_SCORE_RST = 8'd10;
  localparam logic [CFG_W-1:0] UPPER_BOUND_RST   = 8'd100;
  localparam logic [CFG_W-1:0] LOWER_BOUND_RST   = 8'd1;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_SEL  = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    STP_FETCH,
    STP_DISPATCH,
    STP_INC,
    STP_DEC,
    STP_SUM_CLR,
    STP_LOAD,
    STP_SUM,
    STP_ZCHK,
    STP_DIV,
    STP_WALK_INIT,
    STP_WALK,
    STP_EMIT
  } step_t;

  typedef enum logic [3:0] {
    DP_FETCH,
    DP_NONE,
    DP_INC,
    DP_DEC,
    DP_SUM_CLR,
    DP_LOAD,
    DP_SUM,
    DP_DIV_INIT,
    DP_DIV,
    DP_WALK_INIT,
    DP_WALK,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN_VALID,
    CND_OP,
    CND_CNT_LAST,
    CND_TOT_ZERO,
    CND_DIV_LAST,
    CND_HIT,
    CND_OUT_FREE
  } cond_t;

  // One control word: datapath operation, jump condition and both successors.
  typedef struct packed {
    dp_op_t dp;
    cond_t  cond;
    step_t  on_true;
    step_t  on_false;
  } ctl_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    w = '{DP_NONE, CND_ALWAYS, STP_FETCH, STP_FETCH};
    unique case (s)
      STP_FETCH:     w = '{DP_FETCH,     CND_IN_VALID, STP_DISPATCH,  STP_FETCH};
      STP_DISPATCH:  w = '{DP_NONE,      CND_OP,       STP_FETCH,     STP_FETCH};
      STP_INC:       w = '{DP_INC,       CND_ALWAYS,   STP_EMIT,      STP_EMIT};
      STP_DEC:       w = '{DP_DEC,       CND_ALWAYS,   STP_EMIT,      STP_EMIT};
      STP_SUM_CLR:   w = '{DP_SUM_CLR,   CND_ALWAYS,   STP_SUM,       STP_SUM};
      STP_LOAD:      w = '{DP_LOAD,      CND_ALWAYS,   STP_EMIT,      STP_EMIT};
      STP_SUM:       w = '{DP_SUM,       CND_CNT_LAST, STP_ZCHK,      STP_SUM};
      STP_ZCHK:      w = '{DP_DIV_INIT,  CND_TOT_ZERO, STP_EMIT,      STP_DIV};
      STP_DIV:       w = '{DP_DIV,       CND_DIV_LAST, STP_WALK_INIT, STP_DIV};
      STP_WALK_INIT: w = '{DP_WALK_INIT, CND_ALWAYS,   STP_WALK,      STP_WALK};
      STP_WALK:      w = '{DP_WALK,      CND_HIT,      STP_EMIT,      STP_WALK};
      STP_EMIT:      w = '{DP_EMIT,      CND_OUT_FREE, STP_FETCH,     STP_EMIT};
      default:       w = '{DP_NONE,      CND_ALWAYS,   STP_FETCH,     STP_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [ANGLE_W-1:0] angle_of(logic [DIR_W-1:0] idx);
    return ANGLE_W'(idx * DEG_STEP);
  endfunction

endpackage

// File: rtl/wds_if.sv
// Valid/ready channel interfaces for the selector's request and result items.
// Stand-alone; widths of the result fields follow wds_pkg.
interface wds_in_if #(
  parameter int RANDOM_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [2:0]              direction_index;
  logic [RANDOM_WIDTH-1:0] random_word;

  modport source (output valid, output op, output direction_index, output random_word,
                  input ready);
  modport sink (input valid, input op, input direction_index, input random_word,
                output ready);
endinterface

interface wds_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] chosen_index;
  logic [8:0] chosen_angle;
  logic       zero_total;

  modport source (output valid, output chosen_index, output chosen_angle,
                  output zero_total, input ready);
  modport sink (input valid, input chosen_index, input chosen_angle, input zero_total,
                output ready);
endinterface

// File: rtl/weighted_direction_selector.sv
// Roulette-wheel selector over eight compass directions, run by a microcoded sequencer.
// Depends on wds_pkg and the channel interfaces in wds_if.sv.
//
// Items arrive on in_stream (op, direction_index, random_word) and each one gives
// exactly one result item on out_stream (chosen_index, chosen_angle, zero_total).
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user writes
// them only while idle, which the block itself does not enforce.
// One item is worked on at a time; in_stream.ready is high only in the fetch step.
// Increase, decrease and reload go from the dispatch step through their update step to emit.
// A select clears the sum, adds up the eight scores, checks the total for zero, runs the
// bit-serial remainder unit over R random bits (R is the lower of RANDOM_WIDTH and 16),
// sets up the walk and walks the cumulative sums up to the chosen index, then emits.
// A select that finds a total of zero goes straight from the zero check to the emit step.
// Reset restores the register defaults and sets every score to the initial score.
// The result sits in an output register; if the receiver stalls, the next item may
// still be accepted and worked on, and the sequencer waits in its emit step until
// the output register is free.
module weighted_direction_selector
  import wds_pkg::*;
#(
  parameter int SCORE_WIDTH  = 8,
  parameter int RANDOM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wds_in_if.sink               in_stream,
  wds_out_if.source            out_stream,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW      = (SCORE_WIDTH > CFG_W) ? SCORE_WIDTH : CFG_W;
  localparam int TOT_W   = SCORE_WIDTH + DIR_W;
  localparam int RND_EFF = (RANDOM_WIDTH < 16) ? RANDOM_WIDTH : 16;
  localparam int BC_W    = $clog2(RND_EFF);
  localparam logic [SCORE_WIDTH-1:0] SCORE_MAX = {SCORE_WIDTH{1'b1}};
  localparam logic [CW-1:0] SCORE_MAX_EXT = CW'(SCORE_MAX);
  localparam logic [SCORE_WIDTH-1:0] RESET_SCORE =
    (CW'(INITIAL_SCORE_RST) > SCORE_MAX_EXT) ? SCORE_MAX : SCORE_WIDTH'(INITIAL_SCORE_RST);

  // Control and configuration state.
  step_t                  step_r, step_nxt;
  logic [CFG_W-1:0]       init_r, upper_r, lower_r;
  logic [SCORE_WIDTH-1:0] scores_r   [NUM_DIRS];
  logic [SCORE_WIDTH-1:0] scores_nxt [NUM_DIRS];
  logic                   out_valid_r, out_valid_nxt;

  // Datapath registers.
  op_t                    op_r, op_nxt;
  logic [DIR_W-1:0]       dir_r, dir_nxt;
  logic [RND_EFF-1:0]     rnd_r, rnd_nxt;
  logic [DIR_W-1:0]       cnt_r, cnt_nxt;
  logic [BC_W-1:0]        bit_r, bit_nxt;
  logic [TOT_W-1:0]       tot_r, tot_nxt;
  logic [TOT_W-1:0]       acc_r, acc_nxt;
  logic [TOT_W-1:0]       rem_r, rem_nxt;
  logic [DIR_W-1:0]       idx_r, idx_nxt;
  logic                   zero_r, zero_nxt;
  logic [DIR_W-1:0]       out_index_r, out_index_nxt;
  logic [ANGLE_W-1:0]     out_angle_r, out_angle_nxt;
  logic                   out_zero_r, out_zero_nxt;

  ctl_t                   ctl;
  logic [DIR_W-1:0]       rd_addr;
  logic [SCORE_WIDTH-1:0] rd_score;
  logic [SCORE_WIDTH-1:0] score_init;
  logic                   in_fire;
  logic                   out_free;
  logic [TOT_W-1:0]       acc_sum;
  logic                   hit;
  logic [TOT_W:0]         trial;
  logic                   trial_ge;
  logic                   cond_true;

  assign ctl      = ucode(step_r);
  // Increase and decrease read the addressed direction; the sum and the walk read by counter.
  assign rd_addr  = (ctl.dp == DP_INC || ctl.dp == DP_DEC) ? dir_r : cnt_r;
  assign rd_score = scores_r[rd_addr];
  assign score_init = (CW'(init_r) > SCORE_MAX_EXT) ? SCORE_MAX : SCORE_WIDTH'(init_r);

  assign in_stream.ready = (ctl.dp == DP_FETCH);
  assign in_fire         = in_stream.valid && in_stream.ready;
  assign out_free        = !out_valid_r || out_stream.ready;

  assign acc_sum  = acc_r + TOT_W'(rd_score);
  assign hit      = rem_r < acc_sum;
  assign trial    = {rem_r, rnd_r[RND_EFF-1]};
  assign trial_ge = trial >= {1'b0, tot_r};

  assign out_stream.valid        = out_valid_r;
  assign out_stream.chosen_index = out_index_r;
  assign out_stream.chosen_angle = out_angle_r;
  assign out_stream.zero_total   = out_zero_r;

  always_comb begin
    unique case (ctl.cond)
      CND_ALWAYS:   cond_true = 1'b1;
      CND_IN_VALID: cond_true = in_stream.valid;
      CND_OP:       cond_true = 1'b1;
      CND_CNT_LAST: cond_true = (cnt_r == DIR_W'(NUM_DIRS - 1));
      CND_TOT_ZERO: cond_true = (tot_r == '0);
      CND_DIV_LAST: cond_true = (bit_r == BC_W'(RND_EFF - 1));
      CND_HIT:      cond_true = hit;
      CND_OUT_FREE: cond_true = out_free;
      default:      cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (ctl.cond == CND_OP) begin
      unique case (op_r)
        OP_INC:  step_nxt = STP_INC;
        OP_DEC:  step_nxt = STP_DEC;
        OP_SEL:  step_nxt = STP_SUM_CLR;
        OP_LOAD: step_nxt = STP_LOAD;
        default: step_nxt = STP_FETCH;
      endcase
    end else begin
      step_nxt = cond_true ? ctl.on_true : ctl.on_false;
    end
  end

  always_comb begin
    scores_nxt    = scores_r;
    op_nxt        = op_r;
    dir_nxt       = dir_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    tot_nxt       = tot_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    zero_nxt      = zero_r;
    out_index_nxt = out_index_r;
    out_angle_nxt = out_angle_r;
    out_zero_nxt  = out_zero_r;
    out_valid_nxt = out_valid_r && !out_stream.ready;

    unique case (ctl.dp)
      DP_FETCH: begin
        if (in_fire) begin
          op_nxt   = op_t'(in_stream.op);
          dir_nxt  = in_stream.direction_index;
          rnd_nxt  = in_stream.random_word[RND_EFF-1:0];
          idx_nxt  = '0;
          zero_nxt = 1'b0;
        end
      end
      DP_NONE: ;
      DP_INC: begin
        if (CW'(rd_score) < CW'(upper_r) && rd_score != SCORE_MAX) begin
          scores_nxt[dir_r] = rd_score + SCORE_WIDTH'(1);
        end
      end
      DP_DEC: begin
        if (CW'(rd_score) > CW'(lower_r)) begin
          scores_nxt[dir_r] = rd_score - SCORE_WIDTH'(1);
        end
      end
      DP_SUM_CLR: begin
        tot_nxt = '0;
        cnt_nxt = '0;
      end
      DP_LOAD: begin
        for (int i = 0; i < NUM_DIRS; i++) begin
          scores_nxt[i] = score_init;
        end
      end
      DP_SUM: begin
        tot_nxt = tot_r + TOT_W'(rd_score);
        cnt_nxt = cnt_r + DIR_W'(1);
      end
      DP_DIV_INIT: begin
        rem_nxt  = '0;
        bit_nxt  = '0;
        zero_nxt = (tot_r == '0);
      end
      DP_DIV: begin
        // Restoring division, one random bit per cycle; the remainder stays below the total.
        rem_nxt = trial_ge ? TOT_W'(trial - {1'b0, tot_r}) : TOT_W'(trial);
        rnd_nxt = rnd_r << 1;
        bit_nxt = bit_r + BC_W'(1);
      end
      DP_WALK_INIT: begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      DP_WALK: begin
        acc_nxt = acc_sum;
        cnt_nxt = cnt_r + DIR_W'(1);
        if (hit) begin
          idx_nxt = cnt_r;
        end
      end
      DP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = idx_r;
          out_angle_nxt = angle_of(idx_r);
          out_zero_nxt  = zero_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STP_FETCH;
      out_valid_r <= 1'b0;
      init_r      <= INITIAL_SCORE_RST;
      upper_r     <= UPPER_BOUND_RST;
      lower_r     <= LOWER_BOUND_RST;
      for (int i = 0; i < NUM_DIRS; i++) begin
        scores_r[i] <= RESET_SCORE;
      end
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      scores_r    <= scores_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INITIAL_SCORE: init_r  <= cfg_wdata;
          REG_UPPER_BOUND:   upper_r <= cfg_wdata;
          REG_LOWER_BOUND:   lower_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    dir_r       <= dir_nxt;
    rnd_r       <= rnd_nxt;
    cnt_r       <= cnt_nxt;
    bit_r       <= bit_nxt;
    tot_r       <= tot_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    zero_r      <= zero_nxt;
    out_index_r <= out_index_nxt;
    out_angle_r <= out_angle_nxt;
    out_zero_r  <= out_zero_nxt;
  end

endmodule

// File: rtl/wds_checker.sv
// Port-level assertions for the weighted direction selector, bound to the top level.
// Depends on wds_pkg and on weighted_direction_selector for the bind.
module wds_checker
  import wds_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIR_W-1:0]   out_index,
  input logic [ANGLE_W-1:0] out_angle,
  input logic               out_zero
);

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_angle) && $stable(out_zero))
    else $error("stalled result item changed");

  // The angle always matches the index it was derived from.
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle == angle_of(out_index))
    else $error("chosen_angle does not match chosen_index");

  // A select with no weight makes no choice.
  a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero |-> out_index == '0)
    else $error("zero total reported with a nonzero index");

  // One item at a time: the sequencer leaves its fetch step after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted straight after the first");

endmodule

bind weighted_direction_selector wds_checker u_wds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_index (out_stream.chosen_index),
  .out_angle (out_stream.chosen_angle),
  .out_zero  (out_stream.zero_total)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for weighted_direction_selector: directed and random items
// are checked against a score-table predictor kept inside this module.
// Depends on wds_pkg, the channel interfaces in wds_if.sv and the selector itself.
module tb
  import wds_pkg::*;
();

  localparam int SCORE_W = 8;
  localparam int RAND_W  = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES  = 200;
  localparam int PHASE_ITEMS   = 150;

  typedef struct packed {
    logic [DIR_W-1:0]   index;
    logic [ANGLE_W-1:0] angle;
    logic               zero;
  } pick_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  wds_in_if #(.RANDOM_WIDTH(RAND_W)) in_if ();
  wds_out_if                         out_if ();

  weighted_direction_selector #(
    .SCORE_WIDTH (SCORE_W),
    .RANDOM_WIDTH(RAND_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_if),
    .out_stream(out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: the score table and the three bounds.
  logic [SCORE_W-1:0] score_tab [NUM_DIRS];
  logic [CFG_W-1:0]   init_score;
  logic [CFG_W-1:0]   upper_lim;
  logic [CFG_W-1:0]   lower_lim;

  pick_t       pending_picks [$];
  int unsigned failures = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned rx_hold  = 0;
  logic [DIR_W-1:0] hot_dir = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void load_scores();
    int i;
    for (i = 0; i < NUM_DIRS; i++) score_tab[i] = init_score;
  endfunction

  // Applies one operation to the score table and returns the result it should give.
  function automatic pick_t apply_op(op_t op, logic [DIR_W-1:0] dir, logic [RAND_W-1:0] rnd);
    pick_t       res;
    int unsigned total;
    int unsigned bin;
    int unsigned run;
    bit          found;
    int          i;
    res   = '0;
    total = 0;
    run   = 0;
    found = 1'b0;
    case (op)
      // The score is only raised while below the upper bound, which fits the score width, so no wrap.
      OP_INC: if (score_tab[dir] < upper_lim) score_tab[dir] = score_tab[dir] + 1'b1;
      OP_DEC: if (score_tab[dir] > lower_lim) score_tab[dir] = score_tab[dir] - 1'b1;
      OP_LOAD: load_scores();
      OP_SEL: begin
        for (i = 0; i < NUM_DIRS; i++) total += score_tab[i];
        if (total == 0) begin
          res.zero = 1'b1;
        end else begin
          bin = rnd % total;
          for (i = 0; i < NUM_DIRS; i++) begin
            run += score_tab[i];
            if (!found && bin < run) begin
              res.index = DIR_W'(i);
              found     = 1'b1;
            end
          end
          res.angle = ANGLE_W'(int'(res.index) * DEG_STEP);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(op_t op, logic [DIR_W-1:0] dir, logic [RAND_W-1:0] rnd);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.op              <= op;
    in_if.direction_index <= dir;
    in_if.random_word     <= rnd;
    do @(posedge clk); while (!in_if.ready);
    pending_picks.push_back(apply_op(op, dir, rnd));
  endtask

  task automatic send_random_item();
    int unsigned      r;
    op_t              op;
    logic [DIR_W-1:0] dir;
    logic [RAND_W-1:0] rnd;
    r = $urandom_range(0, 99);
    if (r < 35)      op = OP_INC;
    else if (r < 60) op = OP_DEC;
    else if (r < 95) op = OP_SEL;
    else             op = OP_LOAD;
    // Leaning on one direction drives its score into the bounds.
    dir = $urandom_range(0, 1) ? hot_dir : DIR_W'($urandom_range(0, 7));
    rnd = ($urandom_range(0, 3) == 0) ? RAND_W'($urandom_range(0, 255))
                                      : RAND_W'($urandom_range(0, 65535));
    send_item(op, dir, rnd);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_INITIAL_SCORE: init_score = data;
      REG_UPPER_BOUND:   upper_lim  = data;
      REG_LOWER_BOUND:   lower_lim  = data;
      default: ;
    endcase
  endtask

  // Writes all three bounds, plus the unused index, which must change nothing.
  task automatic set_regs(logic [CFG_W-1:0] init_v, logic [CFG_W-1:0] upper_v,
                          logic [CFG_W-1:0] lower_v);
    drain();
    cfg_write(REG_INITIAL_SCORE, init_v);
    cfg_write(REG_SPARE, CFG_W'($urandom_range(0, 255)));
    cfg_write(REG_UPPER_BOUND, upper_v);
    cfg_write(REG_LOWER_BOUND, lower_v);
    cfg_we <= 1'b0;
  endtask

  task automatic test_select_at_reset();
    // All eight scores are ten after reset, so every bin is ten wide.
    send_item(OP_SEL, 3'd0, 16'd0);
    send_item(OP_SEL, 3'd7, 16'd9);
    send_item(OP_SEL, 3'd2, 16'd10);
    send_item(OP_SEL, 3'd5, 16'd79);
    send_item(OP_SEL, 3'd1, 16'd80);
    send_item(OP_INC, 3'd7, 16'hFFFF);
    send_item(OP_DEC, 3'd0, 16'hA5A5);
    send_item(OP_SEL, 3'd4, 16'hFFFF);
  endtask

  task automatic test_score_extremes();
    set_regs(8'd0, 8'd255, 8'd0);
    send_item(OP_LOAD, 3'd5, 16'h1234);
    send_item(OP_SEL, 3'd3, 16'd1234);
    send_item(OP_DEC, 3'd0, 16'd0);
    send_item(OP_INC, 3'd7, 16'd0);
    send_item(OP_SEL, 3'd0, 16'hFFFF);

    set_regs(8'd254, 8'd255, 8'd255);
    send_item(OP_LOAD, 3'd0, 16'd0);
    send_item(OP_INC, 3'd3, 16'd0);
    send_item(OP_INC, 3'd3, 16'd0);
    send_item(OP_DEC, 3'd3, 16'd0);
    send_item(OP_SEL, 3'd6, 16'hFFFF);

    set_regs(8'd255, 8'd0, 8'd0);
    send_item(OP_LOAD, 3'd2, 16'hFFFF);
    send_item(OP_INC, 3'd0, 16'd0);
    send_item(OP_DEC, 3'd0, 16'd0);
    send_item(OP_SEL, 3'd7, 16'd0);
    send_item(OP_SEL, 3'd1, 16'hFFFF);
  endtask

  task automatic test_output_stall();
    // The receiver holds off while items keep coming, so the block has to stall its input.
    tx_quiet = 1'b1;
    rx_hold  = STALL_CYCLES;
    repeat (12) send_random_item();
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_settings();
    int p;
    for (p = 0; p < 8; p++) begin
      case (p)
        0:       set_regs(INITIAL_SCORE_RST, UPPER_BOUND_RST, LOWER_BOUND_RST);
        1:       set_regs(8'd0, 8'd255, 8'd0);
        2:       set_regs(8'd255, 8'd255, 8'd255);
        3:       set_regs(8'd255, 8'd0, 8'd0);
        4:       set_regs(8'd0, 8'd0, 8'd255);
        default: set_regs(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(20, 255)),
                          CFG_W'($urandom_range(0, 20)));
      endcase
      tx_quiet = (p % 3 == 1);
      rx_quiet = (p % 3 == 2);
      hot_dir  = DIR_W'($urandom_range(0, 7));
      send_item(OP_LOAD, DIR_W'($urandom_range(0, 7)), RAND_W'($urandom_range(0, 65535)));
      repeat (PHASE_ITEMS) send_random_item();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Receiver: a random wait before each result item, and a long hold when asked.
  initial begin
    int unsigned wait_n;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      wait_n = rx_quiet ? 0 : $urandom_range(0, 9);
      if (wait_n > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_picks.size() == 0) begin
        $error("result item arrived with no item outstanding");
        failures++;
      end else begin
        want = pending_picks.pop_front();
        if (out_if.chosen_index !== want.index) begin
          $error("chosen_index: expected %0d, got %0d", want.index, out_if.chosen_index);
          failures++;
        end
        if (out_if.chosen_angle !== want.angle) begin
          $error("chosen_angle: expected %0d, got %0d", want.angle, out_if.chosen_angle);
          failures++;
        end
        if (out_if.zero_total !== want.zero) begin
          $error("zero_total: expected %0d, got %0d", want.zero, out_if.zero_total);
          failures++;
        end
      end
    end
  end

  initial begin
    in_if.valid           <= 1'b0;
    in_if.op              <= OP_INC;
    in_if.direction_index <= '0;
    in_if.random_word     <= '0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_INITIAL_SCORE;
    cfg_wdata             <= '0;
    rst_n                 <= 1'b0;
    init_score = INITIAL_SCORE_RST;
    upper_lim  = UPPER_BOUND_RST;
    lower_lim  = LOWER_BOUND_RST;
    load_scores();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_select_at_reset();
    test_score_extremes();
    test_output_stall();
    test_random_settings();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
